@@ design/ial_pkg.sv @@
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants for the indexed array list engine.
// ----------------------------------------------------------------------------
package ial_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int ADDR_W     = $clog2(LIST_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int DATA_W     = 32;
	localparam int FUNC_W     = 3;
	localparam int STAT_W     = 3;

	localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

	typedef struct packed {
		logic                     we;
		logic [ADDR_W-1:0]        waddr;
		logic signed [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0]        raddr;
	} mem_req_t;

	typedef struct packed {
		logic                     valid;
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] value;
		logic [ADDR_W-1:0]        position;
		logic [CNT_W-1:0]         count;
	} resp_t;

endpackage

@@ design/indexed_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_array_list_engine
// Bounded ordered list of signed words with append, insert, search, read,
// pop and delete requests; one registered response per request.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------
//   request   | start, busy        | func, value, position
//   response  | done (strobe)      | status, result_value, result_position,
//             |                    | entry_count
//
// append, insert at the end, rejected requests and unused codes: response in the
// cycle after start. read and pop pass through a read-wait state. search, insert
// below the end and delete walk the list through the single memory port, moving
// or comparing one entry per cycle.
// busy is high while a request walks the list; done is a one-cycle strobe.
// reset empties the list; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module indexed_array_list_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ial_pkg::FUNC_W-1:0]        func,
	input  logic signed [ial_pkg::DATA_W-1:0] value,
	input  logic [ial_pkg::ADDR_W-1:0]        position,
	output logic                              done,
	output logic [ial_pkg::STAT_W-1:0]        status,
	output logic signed [ial_pkg::DATA_W-1:0] result_value,
	output logic [ial_pkg::ADDR_W-1:0]        result_position,
	output logic [ial_pkg::CNT_W-1:0]         entry_count
);
	import ial_pkg::*;

	mem_req_t                 mem_req;
	resp_t                    resp;
	logic signed [DATA_W-1:0] rdata;
	logic                     done_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] value_q;
	logic [ADDR_W-1:0]        position_q;
	logic [CNT_W-1:0]         count_q;

	ial_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.func     (func),
		.value    (value),
		.position (position),
		.rdata    (rdata),
		.busy     (busy),
		.mem_req  (mem_req),
		.resp     (resp)
	);

	ial_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= resp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp.valid) begin
			status_q   <= resp.status;
			value_q    <= resp.value;
			position_q <= resp.position;
			count_q    <= resp.count;
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign result_value    = value_q;
	assign result_position = position_q;
	assign entry_count     = count_q;

endmodule

@@ design/ial_store.sv @@
// ----------------------------------------------------------------------------
// ial_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ial_store (
	input  logic                             clk,
	input  ial_pkg::mem_req_t                req,
	output logic signed [ial_pkg::DATA_W-1:0] rdata
);
	import ial_pkg::*;

	logic signed [DATA_W-1:0] entry_store [LIST_DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			entry_store[req.waddr] <= req.wdata;
		end
		rdata_q <= entry_store[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/ial_ctrl.sv @@
// ----------------------------------------------------------------------------
// ial_ctrl
// Request sequencer: decodes a request, walks the list one entry per cycle
// through the memory port and produces one response.
// ----------------------------------------------------------------------------
module ial_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ial_pkg::FUNC_W-1:0]        func,
	input  logic signed [ial_pkg::DATA_W-1:0] value,
	input  logic [ial_pkg::ADDR_W-1:0]        position,
	input  logic signed [ial_pkg::DATA_W-1:0] rdata,
	output logic                              busy,
	output ial_pkg::mem_req_t                 mem_req,
	output ial_pkg::resp_t                    resp
);
	import ial_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDW  = 6'b000010,
		ST_INS  = 6'b000100,
		ST_INSF = 6'b001000,
		ST_SRCH = 6'b010000,
		ST_DEL  = 6'b100000
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [ADDR_W-1:0]        ptr_q, ptr_d;
	logic [ADDR_W-1:0]        pos_q, pos_d;
	logic signed [DATA_W-1:0] value_q, value_d;
	logic signed [DATA_W-1:0] rval_q, rval_d;
	logic [CNT_W-1:0]         count_m1;
	logic                     is_full;
	logic                     is_empty;
	logic                     ptr_last;

	assign count_m1 = count_q - CNT_W'(1);
	assign is_full  = (count_q == CNT_W'(LIST_DEPTH));
	assign is_empty = (count_q == '0);
	assign ptr_last = (CNT_W'(ptr_q) == count_m1);
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		ptr_d         = ptr_q;
		pos_d         = pos_q;
		value_d       = value_q;
		rval_d        = rval_q;
		mem_req       = '0;
		mem_req.raddr = ptr_q;
		resp          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					value_d = value;
					pos_d   = position;
					unique case (func)
						FN_APPEND: begin
							resp.valid = 1'b1;
							if (is_full) begin
								resp.status = STAT_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = count_q[ADDR_W-1:0];
								mem_req.wdata = value;
								count_d       = count_q + CNT_W'(1);
							end
						end
						FN_INSERT: begin
							if (is_full) begin
								resp.valid  = 1'b1;
								resp.status = STAT_FULL;
							end else if (CNT_W'(position) > count_q) begin
								resp.valid  = 1'b1;
								resp.status = STAT_BADPOS;
							end else if (CNT_W'(position) == count_q) begin
								resp.valid    = 1'b1;
								resp.position = position;
								mem_req.we    = 1'b1;
								mem_req.waddr = position;
								mem_req.wdata = value;
								count_d       = count_q + CNT_W'(1);
							end else begin
								mem_req.raddr = count_m1[ADDR_W-1:0];
								ptr_d         = count_m1[ADDR_W-1:0];
								state_d       = ST_INS;
							end
						end
						FN_SEARCH: begin
							if (is_empty) begin
								resp.valid  = 1'b1;
								resp.status = STAT_NOTFOUND;
							end else begin
								mem_req.raddr = '0;
								ptr_d         = '0;
								state_d       = ST_SRCH;
							end
						end
						FN_READ: begin
							if (is_empty) begin
								resp.valid  = 1'b1;
								resp.status = STAT_EMPTY;
							end else if (CNT_W'(position) >= count_q) begin
								resp.valid  = 1'b1;
								resp.status = STAT_BADPOS;
							end else begin
								mem_req.raddr = position;
								state_d       = ST_RDW;
							end
						end
						FN_POP: begin
							if (is_empty) begin
								resp.valid  = 1'b1;
								resp.status = STAT_EMPTY;
							end else begin
								mem_req.raddr = count_m1[ADDR_W-1:0];
								count_d       = count_m1;
								state_d       = ST_RDW;
							end
						end
						FN_DELETE: begin
							if (is_empty) begin
								resp.valid  = 1'b1;
								resp.status = STAT_EMPTY;
							end else if (CNT_W'(position) >= count_q) begin
								resp.valid  = 1'b1;
								resp.status = STAT_BADPOS;
							end else begin
								mem_req.raddr = position;
								ptr_d         = position;
								state_d       = ST_DEL;
							end
						end
						default: begin
							resp.valid = 1'b1;
						end
					endcase
				end
			end
			ST_RDW: begin
				resp.valid = 1'b1;
				resp.value = rdata;
				state_d    = ST_IDLE;
			end
			ST_INS: begin
				// move entry up by one
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q + ADDR_W'(1);
				mem_req.wdata = rdata;
				if (ptr_q == pos_q) begin
					state_d = ST_INSF;
				end else begin
					mem_req.raddr = ptr_q - ADDR_W'(1);
					ptr_d         = ptr_q - ADDR_W'(1);
				end
			end
			ST_INSF: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				mem_req.wdata = value_q;
				count_d       = count_q + CNT_W'(1);
				resp.valid    = 1'b1;
				resp.position = pos_q;
				state_d       = ST_IDLE;
			end
			ST_SRCH: begin
				if (rdata == value_q) begin
					resp.valid    = 1'b1;
					resp.position = ptr_q;
					state_d       = ST_IDLE;
				end else if (ptr_last) begin
					resp.valid  = 1'b1;
					resp.status = STAT_NOTFOUND;
					state_d     = ST_IDLE;
				end else begin
					mem_req.raddr = ptr_q + ADDR_W'(1);
					ptr_d         = ptr_q + ADDR_W'(1);
				end
			end
			ST_DEL: begin
				// first read is the removed entry, later ones move down by one
				if (ptr_q == pos_q) begin
					rval_d = rdata;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ptr_q - ADDR_W'(1);
					mem_req.wdata = rdata;
				end
				if (ptr_last) begin
					count_d    = count_m1;
					resp.valid = 1'b1;
					resp.value = (ptr_q == pos_q) ? rdata : rval_q;
					state_d    = ST_IDLE;
				end else begin
					mem_req.raddr = ptr_q + ADDR_W'(1);
					ptr_d         = ptr_q + ADDR_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		resp.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q   <= ptr_d;
		pos_q   <= pos_d;
		value_q <= value_d;
		rval_q  <= rval_d;
	end

endmodule
